[hdl/mfb_pkg.sv]
// shared constants, codes and types of the monochrome framebuffer draw engine
package mfb_pkg;

  // panel geometry
  localparam int PANEL_COLUMNS = 128;
  localparam int PANEL_PAGES   = 8;
  localparam int PANEL_ROWS    = 8 * PANEL_PAGES;
  localparam int STORE_DEPTH   = PANEL_PAGES * PANEL_COLUMNS;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);

  // command codes
  typedef enum logic [2:0] {
    CMD_SET_PIXEL  = 3'd0,
    CMD_CLR_PIXEL  = 3'd1,
    CMD_LINE       = 3'd2,
    CMD_FILL_RECT  = 3'd3,
    CMD_CLR_RECT   = 3'd4,
    CMD_CLR_SCREEN = 3'd5,
    CMD_READ_BYTE  = 3'd6
  } mfb_cmd_t;

  // controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PIXEL,
    ST_LINE,
    ST_RECT,
    ST_CLEAR,
    ST_READ,
    ST_DRAIN,
    ST_DONE
  } mfb_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic pix_op;
    logic line_step;
    logic rect_step;
    logic clr_step;
    logic read_op;
    logic out_load;
  } mfb_dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic line_last;
    logic rect_ok;
    logic rect_last;
    logic clr_last;
  } mfb_dp_sts_t;

  // store address of a column byte in a page
  function automatic logic [ADDR_W-1:0] mfb_addr(input logic [4:0] page,
                                                 input logic [7:0] col);
    int a;
    a = int'(page) * PANEL_COLUMNS + int'(col);
    return ADDR_W'(a);
  endfunction

endpackage

[hdl/mfb_ram.sv]
// generic single write port ram with registered read
module mfb_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/mfb_datapath.sv]
// datapath: walkers for pixel, line, rectangle and clear, read-modify-write pipe, store
module mfb_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  mfb_pkg::mfb_dp_cmd_t dp_cmd,
  output mfb_pkg::mfb_dp_sts_t dp_sts,
  input  logic [2:0]          in_cmd,
  input  logic [7:0]          in_x_start,
  input  logic [7:0]          in_y_start,
  input  logic [7:0]          in_x_end,
  input  logic [7:0]          in_y_end,
  input  logic [2:0]          in_read_page,
  input  logic [6:0]          in_read_column,
  output logic [7:0]          out_read_byte
);
  import mfb_pkg::*;

  // captured command
  logic [7:0] xs_r, ys_r, xe_r, ye_r;
  logic [2:0] pg_r;
  logic [6:0] col_r;
  logic       set_r;

  // pixel and line walker
  logic [7:0] px_r, py_r, px_nxt, py_nxt;
  logic [7:0] dx_r, dy_r, dist_r;
  logic       xdec_r, ydec_r;
  logic [7:0] ex_r, ey_r, ex_nxt, ey_nxt;
  logic [8:0] ex_sum, ey_sum;
  logic       ex_over, ey_over;
  logic [8:0] lcnt_r;
  logic [7:0] ld_dx, ld_dy;

  // rectangle walker
  logic [7:0] rx_r, rx_nxt, x1c, y1c;
  logic [4:0] rpg_r, rpg_nxt;
  logic       row_end;
  logic [2:0] lo_bit, hi_bit;
  logic [7:0] rect_mask;

  // clear sweep
  logic [ADDR_W-1:0] clr_cnt_r;

  // operation issue
  logic              pix_ok, read_ok;
  logic              op_valid, op_set, op_read;
  logic [ADDR_W-1:0] op_addr;
  logic [7:0]        op_mask;

  // read-modify-write stage
  logic              s1_valid_r, s1_set_r, s1_read_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [7:0]        s1_mask_r;
  logic              wr_valid_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [7:0]        wr_data_r;
  logic [7:0]        ram_rdata, merged, new_byte;
  logic [7:0]        rslt_r, out_byte_r;

  // command capture and line setup
  assign ld_dx = (in_x_end >= in_x_start) ? in_x_end - in_x_start : in_x_start - in_x_end;
  assign ld_dy = (in_y_end >= in_y_start) ? in_y_end - in_y_start : in_y_start - in_y_end;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      xs_r   <= in_x_start;
      ys_r   <= in_y_start;
      xe_r   <= in_x_end;
      ye_r   <= in_y_end;
      pg_r   <= in_read_page;
      col_r  <= in_read_column;
      set_r  <= (in_cmd == CMD_SET_PIXEL) || (in_cmd == CMD_LINE) ||
                (in_cmd == CMD_FILL_RECT);
      dx_r   <= ld_dx;
      dy_r   <= ld_dy;
      dist_r <= (ld_dx > ld_dy) ? ld_dx : ld_dy;
      xdec_r <= in_x_end < in_x_start;
      ydec_r <= in_y_end < in_y_start;
    end
  end

  // line stepper: error sums stay at or below dist
  always_comb begin
    ex_sum  = {1'b0, ex_r} + {1'b0, dx_r};
    ey_sum  = {1'b0, ey_r} + {1'b0, dy_r};
    ex_over = ex_sum > {1'b0, dist_r};
    ey_over = ey_sum > {1'b0, dist_r};
    ex_nxt  = ex_over ? 8'(ex_sum - {1'b0, dist_r}) : ex_sum[7:0];
    ey_nxt  = ey_over ? 8'(ey_sum - {1'b0, dist_r}) : ey_sum[7:0];
    px_nxt  = px_r;
    py_nxt  = py_r;
    if (ex_over) begin
      px_nxt = xdec_r ? px_r - 8'd1 : px_r + 8'd1;
    end
    if (ey_over) begin
      py_nxt = ydec_r ? py_r - 8'd1 : py_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      px_r   <= in_x_start;
      py_r   <= in_y_start;
      ex_r   <= '0;
      ey_r   <= '0;
      lcnt_r <= '0;
    end else if (dp_cmd.line_step) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      ex_r   <= ex_nxt;
      ey_r   <= ey_nxt;
      lcnt_r <= lcnt_r + 9'd1;
    end
  end

  // rectangle walker, one column byte per cycle with a row mask per page
  always_comb begin
    x1c = ({1'b0, xe_r} >= 9'(PANEL_COLUMNS)) ? 8'(PANEL_COLUMNS - 1) : xe_r;
    y1c = ({1'b0, ye_r} >= 9'(PANEL_ROWS)) ? 8'(PANEL_ROWS - 1) : ye_r;
    row_end = rx_r == x1c;
    rx_nxt  = row_end ? xs_r : rx_r + 8'd1;
    rpg_nxt = row_end ? rpg_r + 5'd1 : rpg_r;
    lo_bit  = (rpg_r == ys_r[7:3]) ? ys_r[2:0] : 3'd0;
    hi_bit  = (rpg_r == y1c[7:3]) ? y1c[2:0] : 3'd7;
    for (int b = 0; b < 8; b++) begin
      rect_mask[b] = (3'(b) >= lo_bit) && (3'(b) <= hi_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      rx_r  <= in_x_start;
      rpg_r <= in_y_start[7:3];
    end else if (dp_cmd.rect_step) begin
      rx_r  <= rx_nxt;
      rpg_r <= rpg_nxt;
    end
  end

  // clear sweep counter, back at zero after its last address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (dp_cmd.clr_step) begin
      clr_cnt_r <= dp_sts.clr_last ? '0 : clr_cnt_r + 1'b1;
    end
  end

  assign dp_sts.line_last = lcnt_r == ({1'b0, dist_r} + 9'd1);
  assign dp_sts.rect_ok   = (xs_r <= xe_r) && (ys_r <= ye_r) &&
                            ({1'b0, xs_r} < 9'(PANEL_COLUMNS)) &&
                            ({1'b0, ys_r} < 9'(PANEL_ROWS));
  assign dp_sts.rect_last = row_end && (rpg_r == y1c[7:3]);
  assign dp_sts.clr_last  = clr_cnt_r == ADDR_W'(STORE_DEPTH - 1);

  // operation select
  assign pix_ok  = ({1'b0, px_r} < 9'(PANEL_COLUMNS)) && ({1'b0, py_r} < 9'(PANEL_ROWS));
  assign read_ok = ({6'd0, pg_r} < 9'(PANEL_PAGES)) && ({2'd0, col_r} < 9'(PANEL_COLUMNS));

  always_comb begin
    op_valid = 1'b0;
    op_addr  = mfb_addr(py_r[7:3], px_r);
    op_mask  = 8'd1 << py_r[2:0];
    op_set   = set_r;
    op_read  = 1'b0;
    if (dp_cmd.pix_op || dp_cmd.line_step) begin
      op_valid = pix_ok;
    end else if (dp_cmd.rect_step) begin
      op_valid = 1'b1;
      op_addr  = mfb_addr(rpg_r, rx_r);
      op_mask  = rect_mask;
    end else if (dp_cmd.clr_step) begin
      op_valid = 1'b1;
      op_addr  = clr_cnt_r;
      op_mask  = 8'hff;
      op_set   = 1'b0;
    end else if (dp_cmd.read_op) begin
      op_valid = read_ok;
      op_addr  = mfb_addr({2'd0, pg_r}, {1'b0, col_r});
      op_mask  = 8'h00;
      op_read  = 1'b1;
    end
  end

  // read-modify-write: ram read in issue cycle, merge and write next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wr_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= op_valid;
      wr_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= op_addr;
    s1_mask_r <= op_mask;
    s1_set_r  <= op_set;
    s1_read_r <= op_read;
    wr_addr_r <= s1_addr_r;
    wr_data_r <= new_byte;
  end

  // bypass the byte written in the previous cycle, the ram read missed it
  assign merged   = (wr_valid_r && (wr_addr_r == s1_addr_r)) ? wr_data_r : ram_rdata;
  assign new_byte = s1_set_r ? (merged | s1_mask_r) : (merged & ~s1_mask_r);

  mfb_ram #(
    .DATA_W(8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (s1_valid_r),
    .waddr(s1_addr_r),
    .wdata(new_byte),
    .raddr(op_addr),
    .rdata(ram_rdata)
  );

  // result and output register
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      rslt_r <= '0;
    end else if (s1_valid_r && s1_read_r) begin
      rslt_r <= merged;
    end
    if (dp_cmd.out_load) begin
      out_byte_r <= rslt_r;
    end
  end

  assign out_read_byte = out_byte_r;

  // a read back leaves the byte as it was
  a_read_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_read_r) |-> (s1_mask_r == 8'h00))
    else $error("read back op carries a write mask");

  // clear sweep counter is home whenever a command is taken
  a_clr_home: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load |-> (clr_cnt_r == '0))
    else $error("clear counter not at zero on command load");

  // the last line point is the end point
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.line_step && dp_sts.line_last) |-> (px_r == xe_r && py_r == ye_r))
    else $error("line stepper missed its end point");

endmodule

[hdl/mfb_ctrl.sv]
// controller: command sequencing, input and result handshakes
module mfb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [2:0]           in_cmd,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mfb_pkg::mfb_dp_cmd_t dp_cmd,
  input  mfb_pkg::mfb_dp_sts_t dp_sts
);
  import mfb_pkg::*;

  mfb_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, out_free;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    dp_cmd        = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_INIT: begin
        dp_cmd.clr_step = 1'b1;
        if (dp_sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          dp_cmd.load = 1'b1;
          case (in_cmd)
            CMD_SET_PIXEL, CMD_CLR_PIXEL: state_nxt = ST_PIXEL;
            CMD_LINE:                     state_nxt = ST_LINE;
            CMD_FILL_RECT, CMD_CLR_RECT:  state_nxt = ST_RECT;
            CMD_CLR_SCREEN:               state_nxt = ST_CLEAR;
            CMD_READ_BYTE:                state_nxt = ST_READ;
            default:                      state_nxt = ST_DRAIN;
          endcase
        end
      end
      ST_PIXEL: begin
        dp_cmd.pix_op = 1'b1;
        state_nxt     = ST_DRAIN;
      end
      ST_LINE: begin
        dp_cmd.line_step = 1'b1;
        if (dp_sts.line_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_RECT: begin
        dp_cmd.rect_step = dp_sts.rect_ok;
        if (!dp_sts.rect_ok || dp_sts.rect_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_CLEAR: begin
        dp_cmd.clr_step = 1'b1;
        if (dp_sts.clr_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_READ: begin
        dp_cmd.read_op = 1'b1;
        state_nxt      = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          dp_cmd.out_load = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

  // one command at a time: nothing is taken right after a transfer in
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second command taken while one is in flight");

  // a finished command with room at the output shows its result next cycle
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished command produced no result");

  // the result register never loads over a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !dp_cmd.out_load)
    else $error("result overwritten before transfer");

endmodule

[hdl/mono_framebuffer_draw_engine.sv]
// top level of the monochrome page framebuffer draw engine
//
//   channel | ports                                           | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid, in_stall, in_cmd, in_x_start,         | command in
//           | in_y_start, in_x_end, in_y_end, in_read_page,   |
//           | in_read_column                                  |
//   out     | out_valid, out_stall, out_read_byte             | result out
//
// sequence: one command at a time; a pixel or read command goes from its
//   issue state through drain and done to its result, an unused code straight
//   to drain; a line draws dist+2 points, one a cycle, a rectangle one column
//   byte a cycle with rows merged by mask and an empty one none, clear screen
//   sweeps all 1024 bytes; the single write port of the store sets the pace
// reset: synchronous active low; afterwards a sweep clears all 1024 bytes of
//   the store, one byte a cycle, with in_stall high
// stalls: the result waits in an output register; a new command is taken
//   while it waits, and its own result waits for the register to free up
module mono_framebuffer_draw_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_x_start,
  input  logic [7:0] in_y_start,
  input  logic [7:0] in_x_end,
  input  logic [7:0] in_y_end,
  input  logic [2:0] in_read_page,
  input  logic [6:0] in_read_column,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_byte
);
  import mfb_pkg::*;

  // command and status between sequencer and datapath
  mfb_dp_cmd_t dp_cmd;
  mfb_dp_sts_t dp_sts;

  // sequencer: owns both handshakes, the clear sweep after reset and the
  // per-command walk length
  mfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dp_cmd   (dp_cmd),
    .dp_sts   (dp_sts)
  );

  // datapath: coordinate walkers, read-modify-write pipe with write bypass,
  // the frame store and the result register
  mfb_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .dp_cmd        (dp_cmd),
    .dp_sts        (dp_sts),
    .in_cmd        (in_cmd),
    .in_x_start    (in_x_start),
    .in_y_start    (in_y_start),
    .in_x_end      (in_x_end),
    .in_y_end      (in_y_end),
    .in_read_page  (in_read_page),
    .in_read_column(in_read_column),
    .out_read_byte (out_read_byte)
  );

endmodule
